@@ sv/ucs_pkg.sv @@
// ucs_pkg: types, fixed-point constants and the arctangent table of the
// unit complex slerp pipeline; no dependencies
package ucs_pkg;

   typedef enum logic [1:0] {
      CASE_GENERAL  = 2'd0,
      CASE_BLEND    = 2'd1,
      CASE_OPPOSITE = 2'd2
   } case_type;

   typedef struct packed {
      logic signed [15:0] a_real;
      logic signed [15:0] a_imag;
      logic signed [15:0] b_real;
      logic signed [15:0] b_imag;
      logic [16:0]        fraction;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_real;
      logic signed [15:0] out_imag;
      case_type           case_taken;
   } rsp_type;

   // per-item data that rides beside the arithmetic units
   typedef struct packed {
      logic signed [15:0] ar;
      logic signed [15:0] ai;
      logic signed [15:0] br;
      logic signed [15:0] bi;
      logic [16:0]        t;
      case_type           kind;
      logic signed [32:0] c;
      logic signed [32:0] vr;
      logic signed [32:0] vi;
      logic [31:0]        den;
      logic signed [15:0] o2r;
      logic signed [15:0] o2i;
   } side_type;

   localparam int ANG_W      = 34;
   localparam int SQ_STAGES  = 32;
   localparam int DIV_BITS   = 16;
   localparam int DIV_LAT    = DIV_BITS + 2;
   localparam int NUM_W      = 51;
   localparam int DEN_W      = 32;
   localparam int ATAN_ROWS  = 24;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic [31:0]             PI_U32      = 32'd3373259426;

   function automatic logic signed [ANG_W-1:0] atan_q30(input int row);
      logic signed [ANG_W-1:0] v;
      case (row)
         0:  v = 34'sd843314857;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043837;
         3:  v = 34'sd133525159;
         4:  v = 34'sd67021687;
         5:  v = 34'sd33543516;
         6:  v = 34'sd16775851;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194283;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/unit_complex_slerp_top.sv @@
// channel   dir  handshake                width  carries
// req_      in   req_valid / req_stall    81     a, b, fraction (req_type)
// rsp_      out  rsp_valid / rsp_stall    34     out_real, out_imag, case_taken
// csr_      in   csr_valid / csr_ready    15     near_threshold
//
// one item enters per cycle while req_stall is low; each item passes through
// the 32-stage square root, the vectoring and rotation cordic pipelines and
// the 18-stage divider
// reset is synchronous, clears the valid bits and sets the threshold to 33
// a result stalled at the output goes to a skid register; req_stall rises
// only while the skid register is full, which freezes the whole pipeline
// unit_complex_slerp_top: top level; depends on ucs_pkg, ucs_isqrt,
// ucs_vector, ucs_rotate and ucs_divide
module unit_complex_slerp_top
   import ucs_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data
);

   localparam int VEC_LAT = CORDIC_STEPS + 1;

   function automatic logic signed [ANG_W-1:0] fold(input logic signed [ANG_W-1:0] ang);
      logic signed [ANG_W-1:0] r;
      if (ang > HALF_PI_Q30) begin
         r = PI_Q30 - ang;
      end else if (ang < -HALF_PI_Q30) begin
         r = -PI_Q30 - ang;
      end else begin
         r = ang;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
      logic signed [15:0] r;
      if (v > 52'sd32767) begin
         r = 16'sd32767;
      end else if (v < -52'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic        pipe_en;
   logic [14:0] thr_ff;

   // input register
   req_type in_ff;
   logic    v1_ff;

   // products of the dot product and the linear blend
   logic signed [31:0] pab_r_ff, pab_i_ff;
   logic signed [33:0] pva_r_ff, pvb_r_ff, pva_i_ff, pvb_i_ff;
   side_type           s2_side_ff, s2_side_in;
   logic               v2_ff;
   logic [16:0]        t_clamp, w_a;

   side_type           s3_side_ff, s3_side_in;
   logic               v3_ff;

   logic [63:0]        csq_ff, vrsq_ff, visq_ff;
   side_type           s4_side_ff, s4_side_in;
   logic               v4_ff;
   logic signed [34:0] one_plus, one_minus, eps_s;
   case_type           kind_in;
   logic signed [31:0] c32, vr32, vi32;
   logic signed [63:0] csq_in, vrsq_in, visq_in;

   logic [63:0]        rad_ff;
   side_type           s5_side_ff;
   logic               v5_ff;

   logic               sq_valid;
   logic [31:0]        sq_root;
   side_type           sq_side_ff [SQ_STAGES];
   side_type           sq_side;

   logic               vec_valid;
   logic [31:0]        theta;
   side_type           vec_side_ff [VEC_LAT];

   logic [48:0]        m1_ff, m2_ff, m4_ff;
   logic signed [50:0] m3_ff;
   side_type           sa_side_ff;
   logic               va_ff;
   logic [16:0]        w_t;
   logic signed [17:0] h_t;

   logic signed [ANG_W-1:0] ang_a_ff, ang_b_ff, ang_a, ang_b;
   side_type           sb_side_ff;
   logic               vb_ff;

   logic               rot_valid, rot_valid_b;
   logic signed [ANG_W-1:0] sin_a, sin_b;
   side_type           rot_side_ff [CORDIC_STEPS];

   logic signed [49:0] pr_ar_ff, pr_br_ff, pr_ai_ff, pr_bi_ff;
   side_type           sc_side_ff;
   logic               vc_ff;

   logic signed [NUM_W-1:0] num_r_ff, num_i_ff;
   side_type           sd_side_ff, sd_side_in;
   logic               vd_ff;
   logic signed [NUM_W-1:0] sum_r, sum_i;
   logic signed [51:0] rnd_r, rnd_i;

   logic               div_valid, div_valid_i;
   logic signed [15:0] quo_r, quo_i;
   side_type           div_side_ff [DIV_LAT];
   side_type           fin_side;
   rsp_type            fin_rsp;

   rsp_type            out_ff, skid_ff;
   logic               out_valid_ff, skid_valid_ff;
   logic               take;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'd33;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         in_ff <= req_data;
      end
   end

   // stage 2: products
   always_comb begin
      t_clamp = (in_ff.fraction > 17'd65536) ? 17'd65536 : in_ff.fraction;
      w_a     = 17'd65536 - t_clamp;
      s2_side_in      = '0;
      s2_side_in.ar   = in_ff.a_real;
      s2_side_in.ai   = in_ff.a_imag;
      s2_side_in.br   = in_ff.b_real;
      s2_side_in.bi   = in_ff.b_imag;
      s2_side_in.t    = t_clamp;
      s2_side_in.kind = CASE_GENERAL;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pab_r_ff   <= in_ff.a_real * in_ff.b_real;
         pab_i_ff   <= in_ff.a_imag * in_ff.b_imag;
         pva_r_ff   <= in_ff.a_real * $signed({1'b0, w_a});
         pvb_r_ff   <= in_ff.b_real * $signed({1'b0, t_clamp});
         pva_i_ff   <= in_ff.a_imag * $signed({1'b0, w_a});
         pvb_i_ff   <= in_ff.b_imag * $signed({1'b0, t_clamp});
         s2_side_ff <= s2_side_in;
      end
   end

   // stage 3: dot product and blend vector
   always_comb begin
      s3_side_in    = s2_side_ff;
      s3_side_in.c  = 33'(pab_r_ff) + 33'(pab_i_ff);
      s3_side_in.vr = 33'(pva_r_ff + pvb_r_ff);
      s3_side_in.vi = 33'(pva_i_ff + pvb_i_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_side_ff <= s3_side_in;
      end
   end

   // stage 4: case decision and squares
   always_comb begin
      one_plus  = 35'sd1073741824 + 35'(s3_side_ff.c);
      one_minus = 35'sd1073741824 - 35'(s3_side_ff.c);
      eps_s     = $signed({5'b0, thr_ff, 15'b0});
      if (one_plus <= eps_s) begin
         kind_in = CASE_OPPOSITE;
      end else if (one_minus <= eps_s) begin
         kind_in = CASE_BLEND;
      end else begin
         kind_in = CASE_GENERAL;
      end
      // c stays inside 32 bits whenever the general case is taken
      c32     = s3_side_ff.c[31:0];
      vr32    = s3_side_ff.vr[31:0];
      vi32    = s3_side_ff.vi[31:0];
      csq_in  = c32 * c32;
      vrsq_in = vr32 * vr32;
      visq_in = vi32 * vi32;
      s4_side_in      = s3_side_ff;
      s4_side_in.kind = kind_in;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         csq_ff     <= $unsigned(csq_in);
         vrsq_ff    <= $unsigned(vrsq_in);
         visq_ff    <= $unsigned(visq_in);
         s4_side_ff <= s4_side_in;
      end
   end

   // stage 5: radicand, sin^2 for the general case, length^2 of the blend vector otherwise
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_side_ff <= s4_side_ff;
         if (s4_side_ff.kind == CASE_GENERAL) begin
            rad_ff <= (64'd1 << 60) - csq_ff;
         end else begin
            rad_ff <= vrsq_ff + visq_ff;
         end
      end
   end

   ucs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v5_ff),
      .rad       (rad_ff),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_side_ff[0] <= s5_side_ff;
         for (int i = 1; i < SQ_STAGES; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   always_comb begin
      sq_side     = sq_side_ff[SQ_STAGES-1];
      sq_side.den = sq_root;
   end

   ucs_vector #(
      .STEPS (CORDIC_STEPS)
   ) u_vector (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sq_valid),
      .vec_x     (ANG_W'(sq_side.c)),
      .vec_y     ($signed({2'b0, sq_root})),
      .out_valid (vec_valid),
      .theta     (theta)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         vec_side_ff[0] <= sq_side;
         for (int i = 1; i < VEC_LAT; i++) begin
            vec_side_ff[i] <= vec_side_ff[i-1];
         end
      end
   end

   // stage A: angle products
   always_comb begin
      w_t = 17'd65536 - vec_side_ff[VEC_LAT-1].t;
      h_t = 18'sd32768 - $signed({1'b0, vec_side_ff[VEC_LAT-1].t});
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         m1_ff      <= w_t * theta;
         m2_ff      <= vec_side_ff[VEC_LAT-1].t * theta;
         m3_ff      <= h_t * $signed({1'b0, PI_U32});
         m4_ff      <= vec_side_ff[VEC_LAT-1].t * PI_U32;
         sa_side_ff <= vec_side_ff[VEC_LAT-1];
      end
   end

   // stage B: angle select and fold into [-pi/2, pi/2]
   always_comb begin
      if (sa_side_ff.kind == CASE_OPPOSITE) begin
         ang_a = ANG_W'(m3_ff >>> 16);
         ang_b = $signed({1'b0, m4_ff[48:16]});
      end else begin
         ang_a = $signed({1'b0, m1_ff[48:16]});
         ang_b = $signed({1'b0, m2_ff[48:16]});
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ang_a_ff   <= fold(ang_a);
         ang_b_ff   <= fold(ang_b);
         sb_side_ff <= sa_side_ff;
      end
   end

   ucs_rotate #(
      .STEPS (CORDIC_STEPS)
   ) u_rotate_a (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vb_ff),
      .angle     (ang_a_ff),
      .out_valid (rot_valid),
      .sine      (sin_a)
   );

   ucs_rotate #(
      .STEPS (CORDIC_STEPS)
   ) u_rotate_b (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vb_ff),
      .angle     (ang_b_ff),
      .out_valid (rot_valid_b),
      .sine      (sin_b)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rot_side_ff[0] <= sb_side_ff;
         for (int i = 1; i < CORDIC_STEPS; i++) begin
            rot_side_ff[i] <= rot_side_ff[i-1];
         end
      end
   end

   // stage C: weight the endpoints
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pr_ar_ff   <= rot_side_ff[CORDIC_STEPS-1].ar * sin_a;
         pr_br_ff   <= rot_side_ff[CORDIC_STEPS-1].br * sin_b;
         pr_ai_ff   <= rot_side_ff[CORDIC_STEPS-1].ai * sin_a;
         pr_bi_ff   <= rot_side_ff[CORDIC_STEPS-1].bi * sin_b;
         sc_side_ff <= rot_side_ff[CORDIC_STEPS-1];
      end
   end

   // stage D: sums, near-opposite result, divider numerators
   always_comb begin
      sum_r = NUM_W'(pr_ar_ff) + NUM_W'(pr_br_ff);
      sum_i = NUM_W'(pr_ai_ff) + NUM_W'(pr_bi_ff);
      rnd_r = 52'(sum_r) + (52'sd1 <<< 29);
      rnd_i = 52'(sum_i) + (52'sd1 <<< 29);
      sd_side_in     = sc_side_ff;
      sd_side_in.o2r = sat16(rnd_r >>> 30);
      sd_side_in.o2i = sat16(rnd_i >>> 30);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sd_side_ff <= sd_side_in;
         if (sc_side_ff.kind == CASE_BLEND) begin
            num_r_ff <= NUM_W'(sc_side_ff.vr) <<< 15;
            num_i_ff <= NUM_W'(sc_side_ff.vi) <<< 15;
         end else begin
            num_r_ff <= sum_r;
            num_i_ff <= sum_i;
         end
      end
   end

   ucs_divide u_divide_r (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vd_ff),
      .num       (num_r_ff),
      .den       (sd_side_ff.den),
      .out_valid (div_valid),
      .quo       (quo_r)
   );

   ucs_divide u_divide_i (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (vd_ff),
      .num       (num_i_ff),
      .den       (sd_side_ff.den),
      .out_valid (div_valid_i),
      .quo       (quo_i)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         div_side_ff[0] <= sd_side_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            div_side_ff[i] <= div_side_ff[i-1];
         end
      end
   end

   // final select
   always_comb begin
      fin_side            = div_side_ff[DIV_LAT-1];
      fin_rsp.case_taken  = fin_side.kind;
      case (fin_side.kind)
         CASE_OPPOSITE: begin
            fin_rsp.out_real = fin_side.o2r;
            fin_rsp.out_imag = fin_side.o2i;
         end
         CASE_BLEND: begin
            // zero-length blend vector gives the origin
            if (fin_side.den == '0) begin
               fin_rsp.out_real = '0;
               fin_rsp.out_imag = '0;
            end else begin
               fin_rsp.out_real = quo_r;
               fin_rsp.out_imag = quo_i;
            end
         end
         default: begin
            fin_rsp.out_real = quo_r;
            fin_rsp.out_imag = quo_i;
         end
      endcase
   end

   // valid bits of the top-level stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         va_ff <= vec_valid;
         vb_ff <= va_ff;
         vc_ff <= rot_valid && rot_valid_b;
         vd_ff <= vc_ff;
      end
   end

   // output register and skid
   assign take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_ff       <= fin_rsp;
         out_valid_ff <= div_valid && div_valid_i;
      end else if (div_valid && div_valid_i) begin
         skid_ff       <= fin_rsp;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> skid_valid_ff)
      else $error("skid item dropped without being taken");

   a_frozen_pipe: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vd_ff) && $stable(num_r_ff))
      else $error("pipeline moved while frozen");

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      div_valid == div_valid_i)
      else $error("divider lanes out of step");
`endif

endmodule

@@ sv/ucs_isqrt.sv @@
// ucs_isqrt: floor square root of a 64-bit value, one result bit per stage
// depends on ucs_pkg
module ucs_isqrt
   import ucs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] rad,
   output logic        out_valid,
   output logic [31:0] root
);

   logic [63:0]          rem_ff [SQ_STAGES];
   logic [63:0]          res_ff [SQ_STAGES];
   logic [SQ_STAGES-1:0] vld_ff;

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT_V = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_prev, res_prev, sum, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_prev = rad;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         sum = res_prev + BIT_V;
         if (rem_prev >= sum) begin
            rem_in = rem_prev - sum;
            res_in = (res_prev >> 1) + BIT_V;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQ_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[SQ_STAGES-1];
   assign root      = res_ff[SQ_STAGES-1][31:0];

endmodule

@@ sv/ucs_vector.sv @@
// ucs_vector: cordic vectoring pipeline giving atan2(y, x) clamped to [0, pi]
// depends on ucs_pkg
module ucs_vector
   import ucs_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] vec_x,
   input  logic signed [ANG_W-1:0] vec_y,
   output logic                    out_valid,
   output logic [31:0]             theta
);

   logic signed [ANG_W-1:0] x_ff [STEPS+1];
   logic signed [ANG_W-1:0] y_ff [STEPS+1];
   logic signed [ANG_W-1:0] z_ff [STEPS+1];
   logic [STEPS:0]          vld_ff;
   logic signed [ANG_W-1:0] z_clamp;

   // left half plane: pre-rotate by pi/2
   always_ff @(posedge clock) begin
      if (en) begin
         if (vec_x < 0) begin
            x_ff[0] <= vec_y;
            y_ff[0] <= -vec_x;
            z_ff[0] <= HALF_PI_Q30;
         end else begin
            x_ff[0] <= vec_x;
            y_ff[0] <= vec_y;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ANG_W-1:0] ATAN = atan_q30(i);
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
   end

   always_comb begin
      if (z_ff[STEPS] < 0) begin
         z_clamp = '0;
      end else if (z_ff[STEPS] > PI_Q30) begin
         z_clamp = PI_Q30;
      end else begin
         z_clamp = z_ff[STEPS];
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign theta     = z_clamp[31:0];

endmodule

@@ sv/ucs_rotate.sv @@
// ucs_rotate: cordic rotation pipeline giving sin of a folded Q30 angle
// depends on ucs_pkg
module ucs_rotate
   import ucs_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] angle,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] sine
);

   logic signed [ANG_W-1:0] x_ff [STEPS];
   logic signed [ANG_W-1:0] y_ff [STEPS];
   logic signed [ANG_W-1:0] z_ff [STEPS];
   logic [STEPS-1:0]        vld_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ANG_W-1:0] ATAN = atan_q30(i);
      logic signed [ANG_W-1:0] x_prev, y_prev, z_prev;

      if (i == 0) begin : g_first
         assign x_prev = GAIN_Q30;
         assign y_prev = '0;
         assign z_prev = angle;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (z_prev >= 0) begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
               z_ff[i] <= z_prev - ATAN;
            end else begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
               z_ff[i] <= z_prev + ATAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STEPS-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign sine      = y_ff[STEPS-1];

endmodule

@@ sv/ucs_divide.sv @@
// ucs_divide: rounded signed divide saturated to Q1.15, one quotient bit
// per stage after a rounding stage and an overflow stage; depends on ucs_pkg
module ucs_divide
   import ucs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    out_valid,
   output logic signed [15:0]      quo
);

   localparam int REM_W = NUM_W + 1;

   logic                neg_p_ff;
   logic [REM_W-1:0]    n_p_ff;
   logic [DEN_W-1:0]    d_p_ff;

   logic [REM_W-1:0]    rem_ff [DIV_BITS+1];
   logic [DEN_W-1:0]    d_ff   [DIV_BITS+1];
   logic [DIV_BITS-1:0] q_ff   [DIV_BITS+1];
   logic                neg_ff [DIV_BITS+1];
   logic                ovf_ff [DIV_BITS+1];
   logic [DIV_BITS+1:0] vld_ff;

   logic [NUM_W-1:0]    mag;
   logic [DEN_W-1:0]    den_safe;
   logic [DIV_BITS-1:0] q_last;

   always_comb begin
      mag      = (num < 0) ? $unsigned(-num) : $unsigned(num);
      den_safe = (den == '0) ? DEN_W'(1) : den;
   end

   // add half the divisor for rounding half away from zero
   always_ff @(posedge clock) begin
      if (en) begin
         neg_p_ff <= (num < 0);
         n_p_ff   <= REM_W'(mag) + REM_W'(den_safe >> 1);
         d_p_ff   <= den_safe;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n_p_ff;
         d_ff[0]   <= d_p_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg_p_ff;
         ovf_ff[0] <= (n_p_ff >= (REM_W'(d_p_ff) << DIV_BITS));
      end
   end

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
      localparam int K = DIV_BITS - 1 - j;
      logic [REM_W-1:0] cmp;
      assign cmp = REM_W'(d_ff[j]) << K;

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[j+1]   <= d_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            if (rem_ff[j] >= cmp) begin
               rem_ff[j+1] <= rem_ff[j] - cmp;
               q_ff[j+1]   <= q_ff[j] | (DIV_BITS'(1) << K);
            end else begin
               rem_ff[j+1] <= rem_ff[j];
               q_ff[j+1]   <= q_ff[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_BITS:0], in_valid};
      end
   end

   assign q_last = q_ff[DIV_BITS];

   always_comb begin
      if (neg_ff[DIV_BITS]) begin
         if (ovf_ff[DIV_BITS] || q_last > 16'd32768) begin
            quo = -16'sd32768;
         end else begin
            quo = $signed(-q_last);
         end
      end else begin
         if (ovf_ff[DIV_BITS] || q_last > 16'd32767) begin
            quo = 16'sd32767;
         end else begin
            quo = $signed(q_last);
         end
      end
   end

   assign out_valid = vld_ff[DIV_BITS+1];

endmodule
